// File: src/cse_pkg.sv
// Shared types, codes and character helpers for the string escape decoder.
package cse_pkg;

	localparam logic [2:0] M_AWAIT = 3'd0;
	localparam logic [2:0] M_BODY  = 3'd1;
	localparam logic [2:0] M_ESC   = 3'd2;
	localparam logic [2:0] M_HEX   = 3'd3;
	localparam logic [2:0] M_OCT   = 3'd4;
	localparam logic [2:0] M_DONE  = 3'd5;
	localparam logic [2:0] M_FAIL  = 3'd6;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNTERM  = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       last;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic       emit;
		result_t    res;
		logic [2:0] next_mode;
	} body_t;

	// hex value in low nibble, bit 4 set when c is a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, c[3:0]};
		end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// decoded value in low byte, bit 8 set when c is a simple escape
	function automatic logic [8:0] simple_escape(input logic [7:0] c);
		logic [8:0] r;
		r = 9'd0;
		case (c)
			8'h27, 8'h22, 8'h3F, 8'h5C: r = {1'b1, c};
			8'h61: r = {1'b1, 8'h07};
			8'h62: r = {1'b1, 8'h08};
			8'h66: r = {1'b1, 8'h0C};
			8'h6E: r = {1'b1, 8'h0A};
			8'h72: r = {1'b1, 8'h0D};
			8'h74: r = {1'b1, 8'h09};
			8'h76: r = {1'b1, 8'h0B};
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic is_octal(input logic [7:0] c);
		return c inside {[8'h30:8'h37]};
	endfunction

	// one byte seen in the body of the literal
	function automatic body_t body_byte(input logic [7:0] c, input logic [7:0] delim);
		body_t b;
		b.emit = 1'b1;
		b.next_mode = M_BODY;
		b.res = '{out_byte: c, has_byte: 1'b1, last: 1'b0, status: ST_OK};
		if (c == delim) begin
			b.res = '{out_byte: 8'h00, has_byte: 1'b0, last: 1'b1, status: ST_OK};
			b.next_mode = M_DONE;
		end else if (c == CH_BSLASH) begin
			b.emit = 1'b0;
			b.next_mode = M_ESC;
		end
		return b;
	endfunction

endpackage

// File: src/cse_if.sv
// Valid/ready stream interfaces for input characters and decoded results.
interface cse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_text;

	modport source (output valid, output byte_in, output end_of_text, input ready);
	modport sink (input valid, input byte_in, input end_of_text, output ready);
endinterface

interface cse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       last;
	logic [1:0] status;

	modport source (output valid, output out_byte, output has_byte, output last,
		output status, input ready);
	modport sink (input valid, input out_byte, input has_byte, input last,
		input status, output ready);
endinterface

// File: src/c_string_escape_decoder.sv
// C string literal escape decoder: one character per request, up to two results each.
//
//  channel   dir   handshake      payload
//  chars     in    valid/ready    byte_in[7:0], end_of_text
//  results   out   valid/ready    out_byte[7:0], has_byte, last, status[1:0]
//
// One character is taken every cycle that chars.ready is high; the decode is
// combinational logic into a two-entry result register. A character that yields
// two results (a hex or octal escape ended by a non-digit) holds chars.ready low
// while the second result drains. arst_n clears mode, delimiter, escape state
// and result valids.
// Stalls on results back up into chars.ready; no request is lost.
module c_string_escape_decoder
	import cse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	cse_in_if.sink    chars,
	cse_out_if.source results
);

	logic [2:0] mode_q;
	logic [7:0] delim_q;
	logic [7:0] esc_q;
	logic [1:0] oct_q;

	result_t    slot_a_q, slot_b_q;
	logic       a_vld_q, b_vld_q;

	logic       acc, out_fire;

	logic [2:0] mode_d;
	logic [7:0] delim_d;
	logic [7:0] esc_d;
	logic [1:0] oct_d;
	logic       r0_v, r1_v;
	result_t    r0, r1;

	body_t      bb;
	logic [4:0] hx;
	logic [8:0] se;
	logic [1:0] oct_inc;
	logic [7:0] c;

	assign chars.ready = !a_vld_q || (!b_vld_q && results.ready);
	assign acc         = chars.valid && chars.ready;
	assign out_fire    = results.valid && results.ready;

	assign c       = chars.byte_in;
	assign bb      = body_byte(c, delim_q);
	assign hx      = hex_digit(c);
	assign se      = simple_escape(c);
	assign oct_inc = oct_q + 2'd1;

	always_comb begin
		mode_d  = mode_q;
		delim_d = delim_q;
		esc_d   = esc_q;
		oct_d   = oct_q;
		r0_v    = 1'b0;
		r1_v    = 1'b0;
		r0      = '{out_byte: esc_q, has_byte: 1'b1, last: 1'b0, status: ST_OK};
		r1      = bb.res;
		if (chars.end_of_text) begin
			mode_d = M_AWAIT;
			esc_d  = 8'h00;
			oct_d  = 2'd0;
			if (mode_q == M_AWAIT || mode_q == M_BODY) begin
				r0_v = 1'b1;
				r0   = '{out_byte: 8'h00, has_byte: 1'b0, last: 1'b1, status: ST_OK};
			end else if (mode_q == M_ESC || mode_q == M_HEX || mode_q == M_OCT) begin
				r0_v = 1'b1;
				r0   = '{out_byte: 8'h00, has_byte: 1'b0, last: 1'b1, status: ST_UNTERM};
			end
		end else begin
			case (mode_q)
				M_AWAIT: begin
					delim_d = c;
					mode_d  = M_BODY;
				end
				M_BODY: begin
					r0_v   = bb.emit;
					r0     = bb.res;
					mode_d = bb.next_mode;
				end
				M_ESC: begin
					if (se[8]) begin
						r0_v   = 1'b1;
						r0     = '{out_byte: se[7:0], has_byte: 1'b1, last: 1'b0,
							status: ST_OK};
						mode_d = M_BODY;
					end else if (c == CH_X) begin
						esc_d  = 8'h00;
						mode_d = M_HEX;
					end else if (is_octal(c)) begin
						esc_d  = c - CH_ZERO;
						oct_d  = 2'd1;
						mode_d = M_OCT;
					end else begin
						r0_v   = 1'b1;
						r0     = '{out_byte: c, has_byte: 1'b0, last: 1'b1,
							status: ST_UNKNOWN};
						mode_d = M_FAIL;
					end
				end
				M_HEX: begin
					if (hx[4]) begin
						esc_d = {esc_q[3:0], hx[3:0]};
					end else begin
						// escape value first, then the terminating byte as body
						r0_v   = 1'b1;
						r1_v   = bb.emit;
						mode_d = bb.next_mode;
					end
				end
				M_OCT: begin
					if (is_octal(c)) begin
						esc_d = {esc_q[4:0], c[2:0]};
						oct_d = oct_inc;
						if (oct_inc == 2'd3 || oct_inc == 2'd0) begin
							r0_v   = 1'b1;
							r0     = '{out_byte: {esc_q[4:0], c[2:0]}, has_byte: 1'b1,
								last: 1'b0, status: ST_OK};
							oct_d  = 2'd0;
							mode_d = M_BODY;
						end
					end else begin
						r0_v   = 1'b1;
						r1_v   = bb.emit;
						oct_d  = 2'd0;
						mode_d = bb.next_mode;
					end
				end
				default: begin
					mode_d = mode_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_AWAIT;
			delim_q <= 8'h00;
			esc_q   <= 8'h00;
			oct_q   <= 2'd0;
		end else if (acc) begin
			mode_q  <= mode_d;
			delim_q <= delim_d;
			esc_q   <= esc_d;
			oct_q   <= oct_d;
		end
	end

	// result slots: a is the head, b holds a second result of the same request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_q <= 1'b0;
			b_vld_q <= 1'b0;
		end else if (acc) begin
			a_vld_q <= r0_v || r1_v;
			b_vld_q <= r0_v && r1_v;
		end else if (out_fire) begin
			a_vld_q <= b_vld_q;
			b_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			slot_a_q <= r0_v ? r0 : r1;
			slot_b_q <= r1;
		end else if (out_fire) begin
			slot_a_q <= slot_b_q;
		end
	end

	assign results.valid    = a_vld_q;
	assign results.out_byte = slot_a_q.out_byte;
	assign results.has_byte = slot_a_q.has_byte;
	assign results.last     = slot_a_q.last;
	assign results.status   = slot_a_q.status;

`ifndef SYNTHESIS
	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		b_vld_q |-> a_vld_q)
		else $error("second result slot valid without head");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> (!a_vld_q || out_fire))
		else $error("request accepted over a pending result");

	a_second_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && b_vld_q && !acc) |=> (a_vld_q && !b_vld_q))
		else $error("second result lost on drain");

	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !chars.end_of_text && r0_v && r0.last) |=>
		(mode_q == M_DONE || mode_q == M_FAIL))
		else $error("final result without closing mode");
`endif

endmodule
